// ----- hdl/pdft_pkg.sv -----
package pdft_pkg;

  // input item opcodes
  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  // frame layout
  localparam logic [3:0]  FRAME_BITS       = 4'd11;
  localparam logic [3:0]  PARITY_IDX       = 4'd9;
  localparam logic [3:0]  STOP_IDX         = 4'd10;
  localparam logic [3:0]  DATA_BITS        = 4'd8;
  localparam logic [15:0] HALF_PERIOD_RST  = 16'd40;

  typedef struct packed {
    op_e        opcode;
    logic [7:0] byte_value;
  } pdft_in_t;

  typedef struct packed {
    logic clock_line;
    logic data_line;
    logic lines_driven;
    logic busy_res;
    logic dropped;
  } pdft_out_t;

  // decoded command from the front part
  typedef struct packed {
    logic       tick;
    logic       push;
    logic [7:0] scan;
  } pdft_cmd_t;

  // scan queue status
  typedef struct packed {
    logic empty;
    logic full;
  } pdft_qstat_t;

  // level of frame bit idx for a scan byte (start, data lsb first, odd parity, stop)
  function automatic logic frame_bit(input logic [7:0] scan, input logic [3:0] idx);
    logic res;
    res = 1'b0;
    priority if (idx == 4'd0) begin
      res = 1'b0;
    end else if (idx <= DATA_BITS) begin
      res = scan[3'(idx - 4'd1)];
    end else if (idx == PARITY_IDX) begin
      res = ~^scan;
    end else if (idx == STOP_IDX) begin
      res = 1'b1;
    end else begin
      res = 1'b1;
    end
    return res;
  endfunction

endpackage

// ----- hdl/pdft_front.sv -----
module pdft_front
  import pdft_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pdft_in_t  in_data_i,
  output logic      cmd_valid_o,
  output pdft_cmd_t cmd_o,
  input  logic      cmd_ready_i
);

  pdft_cmd_t  slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       acc, take;
  pdft_cmd_t  dec;

  // decode the incoming item
  always_comb begin
    dec.tick = (in_data_i.opcode == OP_TICK);
    dec.push = (in_data_i.opcode == OP_PUSH);
    dec.scan = in_data_i.byte_value;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign acc         = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign take        = cmd_valid_o && cmd_ready_i;

  // pointer and fill update
  always_comb begin
    wr_ptr_d = acc  ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = take ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, acc} - {1'b0, take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // item slots
  always_ff @(posedge clk_i) begin
    if (acc) begin
      slot_q[wr_ptr_q] <= dec;
    end
  end

endmodule

// ----- hdl/pdft_byte_fifo.sv -----
module pdft_byte_fifo
  import pdft_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [7:0]  wdata_i,
  input  logic        pop_i,
  output pdft_qstat_t stat_o,
  output logic [7:0]  rdata_o
);

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  logic [7:0]      mem [FIFO_DEPTH];
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      rdata_q;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CntW'(FIFO_DEPTH));
  assign rdata_o      = rdata_q;

  // pointer wrap and count
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (pop_i) begin
      head_d = (head_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : head_q + PtrW'(1);
    end
    if (push_i) begin
      tail_d = (tail_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : tail_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage write
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[tail_q] <= wdata_i;
    end
  end

  // registered read of the popped entry
  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      rdata_q <= mem[head_q];
    end
  end

endmodule

// ----- hdl/pdft_back.sv -----
module pdft_back
  import pdft_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  pdft_cmd_t   cmd_i,
  output logic        cmd_ready_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pdft_out_t   out_data_o
);

  logic [15:0] period_q;
  logic        sending_q, sending_d;
  logic        phase_high_q, phase_high_d;
  logic [3:0]  bit_idx_q, bit_idx_d;
  logic [15:0] half_cnt_q, half_cnt_d;
  logic        clk_lvl_q, clk_lvl_d;
  logic        dat_lvl_q, dat_lvl_d;
  logic        out_valid_q;
  pdft_out_t   out_data_q, res;

  logic        go, push, pop, drove;
  logic [15:0] cnt_dec;
  logic        ph;
  logic [3:0]  bi, bi_inc;
  pdft_qstat_t qstat;
  logic [7:0]  scan;

  pdft_byte_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(cmd_i.scan),
    .pop_i  (pop),
    .stat_o (qstat),
    .rdata_o(scan)
  );

  // output register frees up or is taken this cycle
  assign cmd_ready_o = !out_valid_q || !out_stall_i;
  assign go          = cmd_valid_i && cmd_ready_o;
  assign push        = go && cmd_i.push && !qstat.full;
  assign pop         = go && cmd_i.tick && !sending_q && !qstat.empty;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // line sequencer for one tick
  always_comb begin
    sending_d    = sending_q;
    phase_high_d = phase_high_q;
    bit_idx_d    = bit_idx_q;
    half_cnt_d   = half_cnt_q;
    clk_lvl_d    = clk_lvl_q;
    dat_lvl_d    = dat_lvl_q;
    drove        = 1'b0;
    ph           = pop ? 1'b1 : phase_high_q;
    bi           = pop ? 4'd0 : bit_idx_q;
    bi_inc       = bi + 4'd1;
    cnt_dec      = (pop ? period_q : half_cnt_q) - 16'd1;
    if (cmd_i.tick && (sending_q || pop)) begin
      sending_d    = 1'b1;
      phase_high_d = ph;
      bit_idx_d    = bi;
      half_cnt_d   = cnt_dec;
      if (cnt_dec == 16'd0) begin
        half_cnt_d = period_q;
        drove      = 1'b1;
        if (ph) begin
          phase_high_d = 1'b0;
          clk_lvl_d    = 1'b1;
          if (bi == 4'd0) begin
            dat_lvl_d = 1'b0;
            bit_idx_d = 4'd1;
          end else begin
            bit_idx_d = bi_inc;
            if (bi_inc >= FRAME_BITS) begin
              sending_d    = 1'b0;
              phase_high_d = 1'b1;
              dat_lvl_d    = 1'b1;
            end
          end
        end else begin
          // low half: put the next frame bit on data
          phase_high_d = 1'b1;
          dat_lvl_d    = frame_bit(scan, bi);
          clk_lvl_d    = 1'b0;
        end
      end
    end
    res.clock_line   = clk_lvl_d;
    res.data_line    = dat_lvl_d;
    res.lines_driven = drove;
    res.busy_res     = sending_d;
    res.dropped      = cmd_i.push && qstat.full;
  end

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= HALF_PERIOD_RST;
    end else if (cfg_we_i) begin
      period_q <= cfg_data_i;
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q    <= 1'b0;
      phase_high_q <= 1'b1;
      bit_idx_q    <= 4'd0;
      half_cnt_q   <= 16'd0;
      clk_lvl_q    <= 1'b1;
      dat_lvl_q    <= 1'b1;
    end else if (go) begin
      sending_q    <= sending_d;
      phase_high_q <= phase_high_d;
      bit_idx_q    <= bit_idx_d;
      half_cnt_q   <= half_cnt_d;
      clk_lvl_q    <= clk_lvl_d;
      dat_lvl_q    <= dat_lvl_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_ready_o) begin
      out_valid_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_data_q <= res;
    end
  end

endmodule

// ----- hdl/ps2_device_frame_transmitter.sv -----
// channel | dir | handshake              | payload
// in      | in  | in_valid_i / in_stall_o   | in_data_i  (pdft_in_t: opcode, byte_value)
// out     | out | out_valid_o / out_stall_i | out_data_o (pdft_out_t: line levels, flags)
// cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_data_i (half_period, 16 bits)
//
// one result per item; an item enters every cycle unless input stalls, and its result
// goes via the item queue to the output register, set by one tick/push sequencer step.
// a two-slot item queue in front lets input keep flowing while a result is held.
// reset is asynchronous, active low; no clearing pass, the scan queue needs none.
// input stalls only when both queue slots are full behind a stalled output.
module ps2_device_frame_transmitter
  import pdft_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pdft_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pdft_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic      cmd_valid, cmd_ready;
  pdft_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  // front: item queue and decode
  pdft_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_ready_i(cmd_ready)
  );

  // back: scan queue, line sequencer, result register
  pdft_back #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_ready_o(cmd_ready),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

`ifndef NO_ASSERTIONS
  // a dropped push result never reports driven lines
  a_drop_no_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.dropped && out_data_o.lines_driven))
    else $error("dropped and lines_driven both set");

  // when no frame is in progress both lines idle high
  a_idle_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.busy_res) |-> (out_data_o.clock_line && out_data_o.data_line))
    else $error("lines not high while idle");

  // the item queue only fills up behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");
`endif

endmodule

// ----- dv/ps2_device_frame_transmitter_test.sv -----
`timescale 1ns / 1ps

module ps2_device_frame_transmitter_test;
  import pdft_pkg::*;

  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned ZERO_TICKS = 24;

  // expected line levels of the transmitter, one entry per accepted item
  class ps2_line_predictor;
    logic [15:0] half_period;
    logic [7:0]  scan_q[FIFO_DEPTH];
    logic [3:0]  q_head;
    logic [3:0]  q_tail;
    logic [4:0]  q_count;
    logic [10:0] frame;
    logic [3:0]  bit_idx;
    logic [15:0] half_cnt;
    logic        phase_high;
    logic        sending;
    logic        clk_lvl;
    logic        data_lvl;
    pdft_out_t   levels_due[$];
    int          n_items;
    int          n_checked;
    int          n_frames;
    int          n_drops;
    int          n_driven;
    int          errors;

    function new();
      half_period = HALF_PERIOD_RST;
      q_head      = '0;
      q_tail      = '0;
      q_count     = '0;
      frame       = '0;
      bit_idx     = '0;
      half_cnt    = '0;
      phase_high  = 1'b1;
      sending     = 1'b0;
      clk_lvl     = 1'b1;
      data_lvl    = 1'b1;
      n_items     = 0;
      n_checked   = 0;
      n_frames    = 0;
      n_drops     = 0;
      n_driven    = 0;
      errors      = 0;
    endfunction

    // one tick of the frame sequencer, returns 1 when the lines were driven
    function bit line_tick();
      logic [7:0] scan;
      if (!sending) begin
        if (q_count == 0) return 1'b0;
        scan     = scan_q[q_head];
        q_head   = q_head + 4'd1;
        q_count  = q_count - 5'd1;
        // stop, odd parity, data lsb first, start
        frame    = {1'b1, ~^scan, scan, 1'b0};
        bit_idx  = '0;
        sending  = 1'b1;
        half_cnt = half_period;
        phase_high = 1'b1;
        n_frames++;
      end
      half_cnt = half_cnt - 16'd1;
      if (half_cnt != 0) return 1'b0;
      half_cnt = half_period;
      if (phase_high) begin
        phase_high = 1'b0;
        clk_lvl    = 1'b1;
        if (bit_idx == 0) begin
          data_lvl = 1'b0;
          bit_idx  = 4'd1;
        end else begin
          bit_idx = bit_idx + 4'd1;
          // clock rose on the stop bit, frame done
          if (bit_idx >= FRAME_BITS) begin
            sending    = 1'b0;
            phase_high = 1'b1;
            data_lvl   = 1'b1;
          end
        end
      end else begin
        phase_high = 1'b1;
        data_lvl   = frame[bit_idx];
        clk_lvl    = 1'b0;
      end
      return 1'b1;
    endfunction

    // accepted input item: advance the model and queue its result
    function void take_item(pdft_in_t it);
      pdft_out_t r;
      r = '0;
      n_items++;
      if (it.opcode == OP_PUSH) begin
        if (q_count >= 5'(FIFO_DEPTH)) begin
          r.dropped = 1'b1;
          n_drops++;
        end else begin
          scan_q[q_tail] = it.byte_value;
          q_tail  = q_tail + 4'd1;
          q_count = q_count + 5'd1;
        end
      end else begin
        r.lines_driven = line_tick();
        if (r.lines_driven) n_driven++;
      end
      r.clock_line = clk_lvl;
      r.data_line  = data_lvl;
      r.busy_res   = sending;
      levels_due.push_back(r);
    endfunction

    // accepted result item against the oldest expectation
    function void match_levels(pdft_out_t got);
      pdft_out_t want;
      logic [4:0] g;
      logic [4:0] w;
      string names[5];
      names = '{"clock_line", "data_line", "lines_driven", "busy_res", "dropped"};
      if (levels_due.size() == 0) begin
        $error("result item with no input item waiting: %b", got);
        errors++;
        return;
      end
      want = levels_due.pop_front();
      g = got;
      w = want;
      n_checked++;
      for (int i = 0; i < 5; i++) begin
        if (g[4-i] !== w[4-i]) begin
          $error("%s: expected %0b, actual %0b", names[i], w[4-i], g[4-i]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    function bit quiet();
      return !sending && (q_count == 0);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  pdft_in_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  pdft_out_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  bit          calm = 1'b0;
  int unsigned cycles = 0;
  ps2_line_predictor lines;

  ps2_device_frame_transmitter #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: check accepted items, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) lines.match_levels(out_data_o);
    out_stall_i <= !calm && ($urandom_range(99) < 28);
  end

  // random gaps on the input side
  task automatic idle_gap();
    while (!calm && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_item(input pdft_in_t it);
    idle_gap();
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    lines.take_item(it);
  endtask

  task automatic send_op(input op_e op, input logic [7:0] value);
    pdft_in_t it;
    it.opcode     = op;
    it.byte_value = value;
    send_item(it);
  endtask

  // stop sending and let every expected result arrive
  task automatic drain();
    in_valid_i <= 1'b0;
    while (lines.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_half_period(input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    lines.half_period = value;
  endtask

  // random mix of pushes and ticks at one half period
  task automatic random_phase(input logic [15:0] hp, input int count, input int push_pct,
                              input bit no_idle);
    drain();
    write_half_period(hp);
    calm = no_idle;
    for (int i = 0; i < count; i++) begin
      send_op(($urandom_range(99) < push_pct) ? OP_PUSH : OP_TICK, 8'($urandom_range(255)));
    end
    calm = 1'b0;
  endtask

  initial begin
    lines = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle tick on empty queue, byte extremes, overfill with drop,
    // frame start at the reset half period
    send_op(OP_TICK, 8'h00);
    send_op(OP_PUSH, 8'h00);
    send_op(OP_PUSH, 8'hff);
    send_op(OP_PUSH, 8'h01);
    send_op(OP_PUSH, 8'h80);
    send_op(OP_PUSH, 8'h7f);
    send_op(OP_PUSH, 8'hfe);
    for (int i = 0; i < 11; i++) send_op(OP_PUSH, 8'($urandom_range(255)));
    for (int i = 0; i < 7; i++) send_op(OP_TICK, 8'($urandom_range(255)));

    // random phases; half period of one expires on the start tick too
    random_phase(16'd1, 100, 15, 1'b0);
    random_phase(16'd2, 100, 60, 1'b0);
    random_phase(16'd3, 100, 10, 1'b1);
    random_phase(16'd1, 100, 40, 1'b0);
    random_phase(16'd5, 100, 8, 1'b0);
    random_phase(16'($urandom_range(4, 1)), 100, 30, 1'b0);
    random_phase(HALF_PERIOD_RST, 100, 5, 1'b0);

    // empty the queue and finish the frame at the fastest rate
    drain();
    write_half_period(16'd1);
    while (!lines.quiet()) send_op(OP_TICK, 8'($urandom_range(255)));

    // zero half period: the start tick wraps the counter, no expiry follows
    drain();
    write_half_period(16'd0);
    calm = 1'b1;
    send_op(OP_PUSH, 8'($urandom_range(255)));
    for (int i = 0; i < ZERO_TICKS; i++) send_op(OP_TICK, 8'($urandom_range(255)));
    calm = 1'b0;

    drain();
    if (lines.pending() != 0) begin
      $error("%0d expected results never arrived", lines.pending());
      lines.errors++;
    end
    $display("items %0d, results checked %0d, frames %0d, pushes dropped %0d",
             lines.n_items, lines.n_checked, lines.n_frames, lines.n_drops);
    $display("line drives %0d over half periods 1..5 and 40, plus a wrapped zero",
             lines.n_driven);
    if (lines.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
